>>> rtl/rka_pkg.sv
// Types, action codes and a helper function shared by the ring key ALU.
package rka_pkg;

  localparam int unsigned FieldBits = 64;
  localparam int unsigned ActBits   = 5;
  localparam int unsigned PosBits   = 6;

  typedef enum logic [ActBits-1:0] {
    ACT_ADD       = 5'd0,
    ACT_SUB       = 5'd1,
    ACT_INC       = 5'd2,
    ACT_DEC       = 5'd3,
    ACT_LT        = 5'd4,
    ACT_LE        = 5'd5,
    ACT_GT        = 5'd6,
    ACT_GE        = 5'd7,
    ACT_EQ        = 5'd8,
    ACT_NE        = 5'd9,
    ACT_SUCC      = 5'd10,
    ACT_PRED      = 5'd11,
    ACT_TOPBIT    = 5'd12,
    ACT_IV_OPEN   = 5'd13,
    ACT_IV_CLOSED = 5'd14,
    ACT_IV_LEFT   = 5'd15,
    ACT_IV_RIGHT  = 5'd16
  } action_e;

  typedef struct packed {
    logic [ActBits-1:0]   action;
    logic [FieldBits-1:0] own_key;
    logic [FieldBits-1:0] other_key;
    logic [FieldBits-1:0] upper_bound;
    logic [PosBits-1:0]   shift_amount;
  } req_t;

  typedef struct packed {
    logic [FieldBits-1:0] key_out;
    logic                 flag_out;
    logic [PosBits-1:0]   top_position;
  } rsp_t;

  // Binary-search priority encoder: six halving steps; zero gives zero.
  function automatic logic [PosBits-1:0] top_bit_pos(input logic [FieldBits-1:0] k);
    logic [FieldBits-1:0] v;
    logic [PosBits-1:0]   pos;
    v   = k;
    pos = '0;
    if (|v[63:32]) begin
      pos[5] = 1'b1;
      v      = v >> 32;
    end
    if (|v[31:16]) begin
      pos[4] = 1'b1;
      v      = v >> 16;
    end
    if (|v[15:8]) begin
      pos[3] = 1'b1;
      v      = v >> 8;
    end
    if (|v[7:4]) begin
      pos[2] = 1'b1;
      v      = v >> 4;
    end
    if (|v[3:2]) begin
      pos[1] = 1'b1;
      v      = v >> 2;
    end
    if (v[1]) begin
      pos[0] = 1'b1;
    end
    return pos;
  endfunction

endpackage

>>> rtl/ring_key_alu_top.sv
// Ring key ALU: modular key arithmetic, compares, top bit and ring interval tests.
//
// Usage:
//   Requests enter on in_req_i with in_valid_i/in_ready_o; each carries an
//   action code, the own key, a second key or lower bound, an upper bound and
//   a shift amount. Exactly one response leaves on out_rsp_o with
//   out_valid_o/out_ready_i for every request, in request order.
//   Only the low KEY_BITS bits of each key take part; key_out is zero above.
//   Path: an accepted request goes into the input register, then through
//   one pass of the adder, comparators and priority encoder into the
//   response register, whose valid flag drives out_valid_o.
//   Throughput: one request per cycle while out_ready_i stays high; the
//   single adder/compare pass between the two registers sets that figure.
//   Stall: when out_ready_i is low the response register holds, the input
//   register fills and holds, and in_ready_o drops once both are full.
//   Reset: rst_ni clears both valid flags; no response is pending after it.
module ring_key_alu_top #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rka_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rka_pkg::rsp_t out_rsp_o
);

  typedef logic [KEY_BITS-1:0] key_t;

  rka_pkg::req_t req_q;
  logic          req_valid_q;
  rka_pkg::rsp_t res_q, res_d;
  logic          res_valid_q;
  logic          res_ready;

  assign res_ready  = !res_valid_q || out_ready_i;
  assign in_ready_o = !req_valid_q || res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  // Datapath on the registered request
  key_t own, other, upper, power, addend, sum;
  logic sub_sel;
  logic lt, eq, gt_b, lt_b, eq_ab, a_lt_b;
  logic iv_open, iv_closed, iv_left, iv_right;

  assign own   = req_q.own_key[KEY_BITS-1:0];
  assign other = req_q.other_key[KEY_BITS-1:0];
  assign upper = req_q.upper_bound[KEY_BITS-1:0];
  assign power = (32'(req_q.shift_amount) < KEY_BITS) ?
                 (key_t'(1) << req_q.shift_amount) : '0;

  always_comb begin
    addend  = other;
    sub_sel = 1'b0;
    case (req_q.action)
      rka_pkg::ACT_ADD:  addend = other;
      rka_pkg::ACT_SUB: begin
        addend  = other;
        sub_sel = 1'b1;
      end
      rka_pkg::ACT_INC:  addend = key_t'(1);
      rka_pkg::ACT_DEC: begin
        addend  = key_t'(1);
        sub_sel = 1'b1;
      end
      rka_pkg::ACT_SUCC: addend = power;
      rka_pkg::ACT_PRED: begin
        addend  = power;
        sub_sel = 1'b1;
      end
      default: addend = other;
    endcase
  end

  // Shared adder: subtract by adding the complement plus one
  assign sum = own + (sub_sel ? ~addend : addend) + key_t'(sub_sel);

  assign lt     = own < other;
  assign eq     = own == other;
  assign lt_b   = own < upper;
  assign gt_b   = own > upper;
  assign eq_ab  = other == upper;
  assign a_lt_b = other < upper;

  // Plain arc when a < b, wrapping arc when a > b, full ring when equal (open excludes a)
  always_comb begin
    logic above_open, above_closed, below_open, below_closed;
    above_open   = !lt && !eq;
    above_closed = !lt;
    below_open   = lt_b;
    below_closed = !gt_b;
    if (eq_ab) begin
      iv_open   = !eq;
      iv_closed = 1'b1;
      iv_left   = 1'b1;
      iv_right  = 1'b1;
    end else if (a_lt_b) begin
      iv_open   = above_open && below_open;
      iv_closed = above_closed && below_closed;
      iv_left   = above_closed && below_open;
      iv_right  = above_open && below_closed;
    end else begin
      iv_open   = above_open || below_open;
      iv_closed = above_closed || below_closed;
      iv_left   = above_closed || below_open;
      iv_right  = above_open || below_closed;
    end
  end

  always_comb begin
    res_d = '0;
    case (req_q.action)
      rka_pkg::ACT_ADD, rka_pkg::ACT_SUB, rka_pkg::ACT_INC, rka_pkg::ACT_DEC,
      rka_pkg::ACT_SUCC, rka_pkg::ACT_PRED:
        res_d.key_out = rka_pkg::FieldBits'(sum);
      rka_pkg::ACT_LT:        res_d.flag_out = lt;
      rka_pkg::ACT_LE:        res_d.flag_out = lt || eq;
      rka_pkg::ACT_GT:        res_d.flag_out = !lt && !eq;
      rka_pkg::ACT_GE:        res_d.flag_out = !lt;
      rka_pkg::ACT_EQ:        res_d.flag_out = eq;
      rka_pkg::ACT_NE:        res_d.flag_out = !eq;
      rka_pkg::ACT_TOPBIT:
        res_d.top_position = rka_pkg::top_bit_pos(rka_pkg::FieldBits'(own));
      rka_pkg::ACT_IV_OPEN:   res_d.flag_out = iv_open;
      rka_pkg::ACT_IV_CLOSED: res_d.flag_out = iv_closed;
      rka_pkg::ACT_IV_LEFT:   res_d.flag_out = iv_left;
      rka_pkg::ACT_IV_RIGHT:  res_d.flag_out = iv_right;
      default:                res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_rsp_o   = res_q;

`ifndef NO_ASSERTIONS
  // An accepted request lands in the input register
  a_req_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> req_valid_q)
    else $error("accepted request not captured");

  // A request moving on always produces a response
  a_res_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && res_ready |=> res_valid_q)
    else $error("request dropped between stages");

  // A blocked input register must hold its request
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !res_ready |=> req_valid_q && $stable(req_q))
    else $error("stalled request changed");

  // The key output is zero whenever the flag or the top position is nonzero
  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.flag_out || (res_q.top_position != '0))
      |-> res_q.key_out == '0)
    else $error("response mixes key and flag or position");
`endif

endmodule
